// ===== hdl/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg: shared constants and types for the AABB frustum culler
// Plane register layout, field widths and the plane bank type.
// ----------------------------------------------------------------------------
package afc_pkg;

   localparam int COORD_WIDTH_DEF = 20;
   localparam int NUM_PLANES      = 6;
   localparam int PLANE_W         = 64;
   localparam int NORM_W          = 10;
   localparam int OFFSET_W        = 34;
   localparam int TAG_W           = 16;
   localparam int CSR_IDX_W       = 3;

   // plane register field positions
   localparam int NX_LSB  = 0;
   localparam int NY_LSB  = 10;
   localparam int NZ_LSB  = 20;
   localparam int OFF_LSB = 30;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_TOP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

   typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_bank_type;

endpackage

// ===== hdl/afc_front.sv =====
// ----------------------------------------------------------------------------
// afc_front: request intake
// Accepts a box, forms doubled centers and widths, holds them for the queue.
// ----------------------------------------------------------------------------
module afc_front #(
   parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            start,
   output logic                                            busy,
   input  logic signed [COORD_WIDTH-1:0]                   req_min_x,
   input  logic signed [COORD_WIDTH-1:0]                   req_min_y,
   input  logic signed [COORD_WIDTH-1:0]                   req_min_z,
   input  logic signed [COORD_WIDTH-1:0]                   req_max_x,
   input  logic signed [COORD_WIDTH-1:0]                   req_max_y,
   input  logic signed [COORD_WIDTH-1:0]                   req_max_z,
   input  logic [afc_pkg::TAG_W-1:0]                       req_block_tag,
   output logic                                            push_valid,
   input  logic                                            push_ready,
   output logic [5*(COORD_WIDTH+1)+afc_pkg::TAG_W-1:0]     push_data
);
   import afc_pkg::*;

   localparam int W = COORD_WIDTH + 1;
   localparam int ENTRY_W = 5 * W + TAG_W;

   logic                   valid_ff, valid_in;
   logic [ENTRY_W-1:0]     entry_ff, entry_in;
   logic                   accept;
   logic signed [W-1:0]    sum_x, sum_y, sum_z, wid_x, wid_y;

   // doubled center and widths, extended by one bit
   always_comb begin
      sum_x = W'(req_min_x) + W'(req_max_x);
      sum_y = W'(req_min_y) + W'(req_max_y);
      sum_z = W'(req_min_z) + W'(req_max_z);
      wid_x = W'(req_max_x) - W'(req_min_x);
      wid_y = W'(req_max_y) - W'(req_min_y);
   end

   // stall only when the held request cannot move into the queue
   assign busy   = valid_ff && !push_ready;
   assign accept = start && !busy;

   always_comb begin
      valid_in = accept || (valid_ff && !push_ready);
      entry_in = entry_ff;
      if (accept) begin
         entry_in = {req_block_tag, wid_y, wid_x, sum_z, sum_y, sum_x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push_valid = valid_ff;
   assign push_data  = entry_ff;

endmodule

// ===== hdl/afc_queue.sv =====
// ----------------------------------------------------------------------------
// afc_queue: two-entry request queue
// Decouples the intake from the plane test pipeline.
// ----------------------------------------------------------------------------
module afc_queue #(
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);
   import afc_pkg::*;

   localparam int DEPTH = 2;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != 2'(DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== hdl/afc_back.sv =====
// ----------------------------------------------------------------------------
// afc_back: six-plane test pipeline
// Multiplies, sums and compares per plane, then combines the six verdicts.
// ----------------------------------------------------------------------------
module afc_back #(
   parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  afc_pkg::plane_bank_type                         planes,
   input  logic                                            pop_valid,
   output logic                                            pop_ready,
   input  logic [5*(COORD_WIDTH+1)+afc_pkg::TAG_W-1:0]     pop_data,
   output logic                                            rsp_valid,
   output logic                                            rsp_visible,
   output logic [afc_pkg::TAG_W-1:0]                       rsp_tag_out
);
   import afc_pkg::*;

   localparam int W     = COORD_WIDTH + 1;
   localparam int PD_W  = NORM_W + W;         // normal times doubled center
   localparam int PR_W  = NORM_W + 1 + W;     // |normal| times width
   localparam int D2_W  = OFFSET_W + 1;
   localparam int SUM_W = (COORD_WIDTH + 16 > 37) ? COORD_WIDTH + 16 : 37;

   logic signed [W-1:0] sum_x, sum_y, sum_z, wid_x, wid_y;
   logic [TAG_W-1:0]    tag;

   // pipeline never stalls, so the queue drains every cycle
   assign pop_ready = 1'b1;
   assign {tag, wid_y, wid_x, sum_z, sum_y, sum_x} = pop_data;

   // stage 1: products
   logic                     s1_valid_ff;
   logic [TAG_W-1:0]         s1_tag_ff;
   logic signed [PD_W-1:0]   s1_px_ff [NUM_PLANES];
   logic signed [PD_W-1:0]   s1_py_ff [NUM_PLANES];
   logic signed [PD_W-1:0]   s1_pz_ff [NUM_PLANES];
   logic signed [PR_W-1:0]   s1_rx_ff [NUM_PLANES];
   logic signed [PR_W-1:0]   s1_ry_ff [NUM_PLANES];
   logic signed [PR_W-1:0]   s1_rz_ff [NUM_PLANES];
   logic signed [D2_W-1:0]   s1_d2_ff [NUM_PLANES];

   // stage 2: distance and radius sums
   logic                     s2_valid_ff;
   logic [TAG_W-1:0]         s2_tag_ff;
   logic signed [SUM_W-1:0]  s2_dist_ff [NUM_PLANES];
   logic signed [SUM_W-1:0]  s2_rad_ff [NUM_PLANES];

   // stage 3: per-plane verdicts
   logic                     s3_valid_ff;
   logic [TAG_W-1:0]         s3_tag_ff;
   logic [NUM_PLANES-1:0]    s3_pass_ff;
   wire  [NUM_PLANES-1:0]    s3_pass_in;

   // output registers
   logic                     out_valid_ff;
   logic                     out_visible_ff;
   logic [TAG_W-1:0]         out_tag_ff;

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      logic signed [NORM_W-1:0]   nx, ny, nz;
      logic signed [NORM_W:0]     ax, ay, az;
      logic signed [OFFSET_W-1:0] off;
      logic signed [PD_W-1:0]     px_in, py_in, pz_in;
      logic signed [PR_W-1:0]     rx_in, ry_in, rz_in;
      logic signed [SUM_W-1:0]    dist_in, rad_in, total;

      always_comb begin
         nx  = planes[p][NX_LSB +: NORM_W];
         ny  = planes[p][NY_LSB +: NORM_W];
         nz  = planes[p][NZ_LSB +: NORM_W];
         off = planes[p][OFF_LSB +: OFFSET_W];
         // magnitudes, one bit wider so +2.0, the magnitude of -2.0 Q1.8, fits
         ax  = nx[NORM_W-1] ? -(NORM_W+1)'(nx) : (NORM_W+1)'(nx);
         ay  = ny[NORM_W-1] ? -(NORM_W+1)'(ny) : (NORM_W+1)'(ny);
         az  = nz[NORM_W-1] ? -(NORM_W+1)'(nz) : (NORM_W+1)'(nz);
         px_in = PD_W'(nx) * PD_W'(sum_x);
         py_in = PD_W'(ny) * PD_W'(sum_y);
         pz_in = PD_W'(nz) * PD_W'(sum_z);
         // x width also stands for the z extent
         rx_in = PR_W'(ax) * PR_W'(wid_x);
         ry_in = PR_W'(ay) * PR_W'(wid_y);
         rz_in = PR_W'(az) * PR_W'(wid_x);
      end

      always_comb begin
         dist_in = SUM_W'(s1_px_ff[p]) + SUM_W'(s1_py_ff[p]) + SUM_W'(s1_pz_ff[p])
                 - SUM_W'(s1_d2_ff[p]);
         rad_in  = SUM_W'(s1_rx_ff[p]) + SUM_W'(s1_ry_ff[p]) + SUM_W'(s1_rz_ff[p]);
      end

      always_ff @(posedge clock) begin
         s1_px_ff[p]   <= px_in;
         s1_py_ff[p]   <= py_in;
         s1_pz_ff[p]   <= pz_in;
         s1_rx_ff[p]   <= rx_in;
         s1_ry_ff[p]   <= ry_in;
         s1_rz_ff[p]   <= rz_in;
         s1_d2_ff[p]   <= {off, 1'b0};
         s2_dist_ff[p] <= dist_in;
         s2_rad_ff[p]  <= rad_in;
      end

      // plane passes when distance plus radius is not negative
      assign total         = s2_dist_ff[p] + s2_rad_ff[p];
      assign s3_pass_in[p] = !total[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= pop_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
      s1_tag_ff      <= tag;
      s2_tag_ff      <= s1_tag_ff;
      s3_tag_ff      <= s2_tag_ff;
      s3_pass_ff     <= s3_pass_in;
      out_tag_ff     <= s3_tag_ff;
      out_visible_ff <= &s3_pass_ff;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_visible = out_visible_ff;
   assign rsp_tag_out = out_tag_ff;

endmodule

// ===== hdl/aabb_frustum_cull.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull: six-plane view frustum test for axis-aligned boxes
//
// Request channel: a box (min/max corners) and a tag are taken at a rising
// edge with start high and busy low. Response channel: rsp_valid is high for
// one cycle with rsp_visible and rsp_tag_out; the receiver cannot stall, so
// the test pipeline runs freely and never pushes back.
// The response passes through the intake register, the queue, the product,
// sum and compare stages and the output register after the accepting edge.
// Throughput: one request per cycle; busy only rises if the two-entry queue
// between intake and test pipeline were full, which the free-running
// pipeline keeps from happening.
// Configuration: six 64-bit plane registers written through the csr_ channel
// (index 0..5, other indexes ignored); csr_ready is always high. Write planes
// only while no request is in flight.
// Reset: all planes clear to zero (every box then tests visible) and all
// in-flight requests are dropped.
// ----------------------------------------------------------------------------
module aabb_frustum_cull #(
   parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_WIDTH-1:0]       req_min_x,
   input  logic signed [COORD_WIDTH-1:0]       req_min_y,
   input  logic signed [COORD_WIDTH-1:0]       req_min_z,
   input  logic signed [COORD_WIDTH-1:0]       req_max_x,
   input  logic signed [COORD_WIDTH-1:0]       req_max_y,
   input  logic signed [COORD_WIDTH-1:0]       req_max_z,
   input  logic [afc_pkg::TAG_W-1:0]           req_block_tag,
   output logic                                rsp_valid,
   output logic                                rsp_visible,
   output logic [afc_pkg::TAG_W-1:0]           rsp_tag_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [afc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [afc_pkg::PLANE_W-1:0]         csr_data
);
   import afc_pkg::*;

   localparam int ENTRY_W = 5 * (COORD_WIDTH + 1) + TAG_W;

   plane_bank_type     planes_ff, planes_in;
   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // plane register bank
   assign csr_ready = 1'b1;

   always_comb begin
      planes_in = planes_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PLANE_LEFT:   planes_in[0] = csr_data;
            REG_PLANE_RIGHT:  planes_in[1] = csr_data;
            REG_PLANE_TOP:    planes_in[2] = csr_data;
            REG_PLANE_BOTTOM: planes_in[3] = csr_data;
            REG_PLANE_NEAR:   planes_in[4] = csr_data;
            REG_PLANE_FAR:    planes_in[5] = csr_data;
            default:          planes_in = planes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else begin
         planes_ff <= planes_in;
      end
   end

   afc_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_min_x     (req_min_x),
      .req_min_y     (req_min_y),
      .req_min_z     (req_min_z),
      .req_max_x     (req_max_x),
      .req_max_y     (req_max_y),
      .req_max_z     (req_max_z),
      .req_block_tag (req_block_tag),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   afc_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   afc_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .planes      (planes_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_visible (rsp_visible),
      .rsp_tag_out (rsp_tag_out)
   );

endmodule

// ===== dv/afc_cull_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_cull_check: response checker for the AABB frustum culler
// Keeps its own copy of the six plane registers from the csr channel, works
// out the visibility of every accepted request and checks the response
// stream against it in order.
// ----------------------------------------------------------------------------
module afc_cull_check #(
   parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF,
   parameter int MAX_REPORTS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_min_x,
   input  logic signed [COORD_WIDTH-1:0] req_min_y,
   input  logic signed [COORD_WIDTH-1:0] req_min_z,
   input  logic signed [COORD_WIDTH-1:0] req_max_x,
   input  logic signed [COORD_WIDTH-1:0] req_max_y,
   input  logic signed [COORD_WIDTH-1:0] req_max_z,
   input  logic [afc_pkg::TAG_W-1:0]     req_block_tag,
   input  logic                          rsp_valid,
   input  logic                          rsp_visible,
   input  logic [afc_pkg::TAG_W-1:0]     rsp_tag_out,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [afc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [afc_pkg::PLANE_W-1:0]   csr_data,
   output int                            pending_results,
   output int                            mismatches,
   output int                            boxes_checked,
   output int                            boxes_visible
);
   import afc_pkg::*;

   typedef struct packed {
      logic             visible;
      logic [TAG_W-1:0] tag;
   } cull_verdict_type;

   plane_bank_type   shadow_planes;
   cull_verdict_type verdict_q[$];

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Doubled, Q.8-scaled distance plus radius per plane; the x width stands
   // in for the z extent, and inverted boxes keep their negative widths.
   function automatic logic box_in_frustum(input plane_bank_type bank,
                                           input longint lx, ly, lz,
                                           input longint hx, hy, hz);
      logic signed [NORM_W-1:0]   nx_f, ny_f, nz_f;
      logic signed [OFFSET_W-1:0] off_f;
      longint nx, ny, nz, off, wx, wy, dist2, rad2;
      logic vis;
      vis = 1'b1;
      wx = hx - lx;
      wy = hy - ly;
      for (int i = 0; i < NUM_PLANES; i++) begin
         nx_f  = bank[i][NX_LSB +: NORM_W];
         ny_f  = bank[i][NY_LSB +: NORM_W];
         nz_f  = bank[i][NZ_LSB +: NORM_W];
         off_f = bank[i][OFF_LSB +: OFFSET_W];
         nx  = nx_f;
         ny  = ny_f;
         nz  = nz_f;
         off = off_f;
         dist2 = nx * (lx + hx) + ny * (ly + hy) + nz * (lz + hz) - 2 * off;
         rad2  = wx * magnitude(nx) + wy * magnitude(ny) + wx * magnitude(nz);
         if (dist2 + rad2 < 0)
            vis = 1'b0;
      end
      return vis;
   endfunction

   always @(posedge clock) begin
      cull_verdict_type want;
      if (reset) begin
         shadow_planes = '0;
         verdict_q.delete();
         mismatches    = 0;
         boxes_checked = 0;
         boxes_visible = 0;
      end else begin
         // mirror plane writes; indexes past the last plane are dropped
         if (csr_valid && csr_ready && csr_index < NUM_PLANES)
            shadow_planes[csr_index] = csr_data;

         // predict each accepted request
         if (start && !busy) begin
            want.visible = box_in_frustum(shadow_planes, req_min_x, req_min_y, req_min_z,
                                          req_max_x, req_max_y, req_max_z);
            want.tag     = req_block_tag;
            verdict_q.push_back(want);
         end

         // compare each response with the oldest prediction
         if (rsp_valid === 1'b1) begin
            if (verdict_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("[%0t] response with no request outstanding: visible %0d tag %h",
                           $time, rsp_visible, rsp_tag_out);
            end else begin
               want = verdict_q.pop_front();
               boxes_checked++;
               if (want.visible)
                  boxes_visible++;
               if (rsp_visible !== want.visible || rsp_tag_out !== want.tag) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("[%0t] cull mismatch: visible exp %0d got %0d, tag exp %h got %h",
                              $time, want.visible, rsp_visible, want.tag, rsp_tag_out);
               end
            end
         end
      end
      pending_results <= verdict_q.size();
   end

endmodule

// ===== dv/aabb_frustum_cull_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_tb: testbench top for the AABB frustum culler
// Drives directed boxes against hand-built frustums, then random boxes over
// axis-aligned, tilted, wide and raw plane sets with varying sender idling.
// Checking is done by afc_cull_check; this module makes stimulus and reports.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_tb;
   import afc_pkg::*;

   localparam int     CW              = COORD_WIDTH_DEF;
   localparam longint COORD_MIN       = -(longint'(1) <<< (CW - 1));
   localparam longint COORD_MAX       = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint OFF_MAX         = (longint'(1) <<< (OFFSET_W - 1)) - 1;
   localparam longint OFF_MIN         = -(longint'(1) <<< (OFFSET_W - 1));
   localparam int     UNITY           = 256;   // 1.0 in Q1.8
   localparam int     PHASES          = 12;
   localparam int     ITEMS_PER_PHASE = 128;
   localparam int     SETTLE_CYCLES   = 8;     // pipeline latency plus margin
   localparam int     STALL_LIMIT     = 2000;

   // indexes past the plane bank; writes to them must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = CSR_IDX_W'(NUM_PLANES);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = '1;

   typedef enum int {PLANES_BOX, PLANES_TILTED, PLANES_RAW, PLANES_WIDE} plane_style_type;

   logic                    clock;
   logic                    reset         = 1'b1;
   logic                    start         = 1'b0;
   logic                    busy;
   logic signed [CW-1:0]    req_min_x     = '0;
   logic signed [CW-1:0]    req_min_y     = '0;
   logic signed [CW-1:0]    req_min_z     = '0;
   logic signed [CW-1:0]    req_max_x     = '0;
   logic signed [CW-1:0]    req_max_y     = '0;
   logic signed [CW-1:0]    req_max_z     = '0;
   logic [TAG_W-1:0]        req_block_tag = '0;
   logic                    rsp_valid;
   logic                    rsp_visible;
   logic [TAG_W-1:0]        rsp_tag_out;
   logic                    csr_valid     = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index     = '0;
   logic [PLANE_W-1:0]      csr_data      = '0;

   int pending_results;
   int mismatches;
   int boxes_checked;
   int boxes_visible;
   int csr_writes   = 0;
   int plane_sets   = 0;
   int quiet_cycles = 0;

   aabb_frustum_cull #(.COORD_WIDTH(CW)) dut (.*);

   afc_cull_check #(.COORD_WIDTH(CW)) u_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: give up when no request, response or register write moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint clamp_coord(input longint v);
      if (v < COORD_MIN)
         return COORD_MIN;
      if (v > COORD_MAX)
         return COORD_MAX;
      return v;
   endfunction

   function automatic logic [PLANE_W-1:0] pack_plane(input int nx, ny, nz, input longint off);
      logic [PLANE_W-1:0] p;
      p = '0;
      p[NX_LSB +: NORM_W]    = NORM_W'(nx);
      p[NY_LSB +: NORM_W]    = NORM_W'(ny);
      p[NZ_LSB +: NORM_W]    = NORM_W'(nz);
      p[OFF_LSB +: OFFSET_W] = OFFSET_W'(off);
      return p;
   endfunction

   // inward-facing unit planes around an axis-aligned region
   function automatic plane_bank_type axis_frustum(input longint xlo, xhi, ylo, yhi,
                                                   input longint zlo, zhi);
      plane_bank_type b;
      b[REG_PLANE_LEFT]   = pack_plane(UNITY, 0, 0, UNITY * xlo);
      b[REG_PLANE_RIGHT]  = pack_plane(-UNITY, 0, 0, -UNITY * xhi);
      b[REG_PLANE_TOP]    = pack_plane(0, -UNITY, 0, -UNITY * yhi);
      b[REG_PLANE_BOTTOM] = pack_plane(0, UNITY, 0, UNITY * ylo);
      b[REG_PLANE_NEAR]   = pack_plane(0, 0, UNITY, UNITY * zlo);
      b[REG_PLANE_FAR]    = pack_plane(0, 0, -UNITY, -UNITY * zhi);
      return b;
   endfunction

   // present one request and hold it until accepted; start stays high
   task automatic issue_box(input longint lx, ly, lz, hx, hy, hz,
                            input logic [TAG_W-1:0] tag);
      start         <= 1'b1;
      req_min_x     <= lx[CW-1:0];
      req_min_y     <= ly[CW-1:0];
      req_min_z     <= lz[CW-1:0];
      req_max_x     <= hx[CW-1:0];
      req_max_y     <= hy[CW-1:0];
      req_max_z     <= hz[CW-1:0];
      req_block_tag <= tag;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
   endtask

   // drain: every response in, then let the pipeline empty
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [PLANE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      csr_writes++;
   endtask

   // new frustum, written while idle, plus one write to an unused index
   task automatic load_planes(input plane_bank_type bank,
                              input logic [CSR_IDX_W-1:0] spare_idx,
                              input logic [PLANE_W-1:0] spare_data);
      settle();
      write_csr(REG_PLANE_LEFT, bank[REG_PLANE_LEFT]);
      write_csr(REG_PLANE_RIGHT, bank[REG_PLANE_RIGHT]);
      write_csr(spare_idx, spare_data);
      write_csr(REG_PLANE_TOP, bank[REG_PLANE_TOP]);
      write_csr(REG_PLANE_BOTTOM, bank[REG_PLANE_BOTTOM]);
      write_csr(REG_PLANE_NEAR, bank[REG_PLANE_NEAR]);
      write_csr(REG_PLANE_FAR, bank[REG_PLANE_FAR]);
      csr_valid <= 1'b0;
      plane_sets++;
   endtask

   // mostly boxes around the focus, some inverted, some anywhere at all
   task automatic send_random_box(input longint fx, fy, fz, spread);
      longint f[3];
      longint lo[3];
      longint hi[3];
      longint mid, half, t;
      int roll;
      f[0] = fx;
      f[1] = fy;
      f[2] = fz;
      roll = $urandom_range(0, 99);
      for (int a = 0; a < 3; a++) begin
         if (roll >= 90) begin
            lo[a] = COORD_MIN + longint'($urandom_range(0, (1 << CW) - 1));
            hi[a] = COORD_MIN + longint'($urandom_range(0, (1 << CW) - 1));
         end else begin
            mid   = f[a] + longint'($urandom_range(0, 2 * spread)) - spread;
            half  = longint'($urandom_range(0, spread));
            lo[a] = clamp_coord(mid - half);
            hi[a] = clamp_coord(mid + half);
            if (roll >= 80) begin
               t     = lo[a];
               lo[a] = hi[a];
               hi[a] = t;
            end
         end
      end
      issue_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                TAG_W'($urandom_range(0, (1 << TAG_W) - 1)));
   endtask

   initial begin
      plane_bank_type  bank;
      plane_style_type style;
      longint          fx, fy, fz, spread, half, margin;
      int              idle_pct, nx, ny, nz;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // planes out of reset are all zero: every box passes
      issue_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, '1);
      issue_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, '0);
      issue_box(0, 0, 0, 0, 0, 0, 16'h5A5A);

      // cube frustum of half size 100
      bank = axis_frustum(-100, 100, -100, 100, -100, 100);
      load_planes(bank, REG_SPARE_LO, '0);
      issue_box(-10, -10, -10, 10, 10, 10, 16'h0101);      // inside
      issue_box(-300, -10, -10, -101, 10, 10, 16'h0102);   // past left
      issue_box(-200, -10, -10, -100, 10, 10, 16'h0103);   // touches left, sum exactly zero
      issue_box(101, -10, -10, 300, 10, 10, 16'h0104);     // past right
      issue_box(-1000, -1000, -1000, 1000, 1000, 1000, 16'h0105); // encloses frustum
      issue_box(10, 10, 10, -10, -10, -10, 16'h0106);      // inverted, still inside
      issue_box(300, -10, -10, -300, 10, 10, 16'h0107);    // inverted, negative radius fails
      issue_box(-2, -10, -170, 2, 10, -70, 16'h0108);      // thin in x: z extent too small
      issue_box(-50, -10, -170, 50, 10, -70, 16'h0109);    // wide in x: z extent reaches
      issue_box(-10, 150, -10, 10, 300, 10, 16'h010A);     // above top
      issue_box(-10, -10, 101, 10, 10, 300, 16'h010B);     // beyond far

      // extreme normals and offsets, unnormalized
      bank[REG_PLANE_LEFT]   = '1;
      bank[REG_PLANE_RIGHT]  = pack_plane(-512, 511, -512, OFF_MIN);
      bank[REG_PLANE_TOP]    = 64'h8000_0000_0000_0000;
      bank[REG_PLANE_BOTTOM] = pack_plane(511, -512, 511, 0);
      bank[REG_PLANE_NEAR]   = '0;
      bank[REG_PLANE_FAR]    = pack_plane(511, 511, 511, OFF_MIN);
      load_planes(bank, REG_SPARE_HI, '1);
      issue_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 16'h0201);
      issue_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 16'h0202);
      issue_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 16'h0203);
      issue_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'h0204);

      // largest offset on a zero normal culls everything
      bank[REG_PLANE_NEAR] = pack_plane(0, 0, 0, OFF_MAX);
      load_planes(bank, REG_SPARE_LO, '1);
      issue_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 16'h0301);
      issue_box(0, 0, 0, 0, 0, 0, 16'h0302);

      // random phases; the receiver cannot stall, so its stall phase runs
      // the sender flat out
      for (int p = 0; p < PHASES; p++) begin
         style = plane_style_type'(p % 4);
         case ((p / 3) % 4)
            1:       idle_pct = 56;
            3:       idle_pct = 36;
            default: idle_pct = 0;
         endcase

         case (style)
            PLANES_BOX: begin
               fx     = longint'($urandom_range(0, 400000)) - 200000;
               fy     = longint'($urandom_range(0, 400000)) - 200000;
               fz     = longint'($urandom_range(0, 400000)) - 200000;
               half   = longint'($urandom_range(16, 4000));
               bank   = axis_frustum(fx - half, fx + half, fy - half, fy + half,
                                     fz - half, fz + half);
               spread = 2 * half;
            end
            PLANES_WIDE: begin
               bank = axis_frustum(-longint'($urandom_range(400000, 524288)),
                                   longint'($urandom_range(400000, 524287)),
                                   -longint'($urandom_range(400000, 524288)),
                                   longint'($urandom_range(400000, 524287)),
                                   -longint'($urandom_range(400000, 524288)),
                                   longint'($urandom_range(400000, 524287)));
               fx = 0;
               fy = 0;
               fz = 0;
               spread = COORD_MAX;
            end
            PLANES_TILTED: begin
               // random normals through points near an anchor
               fx = longint'($urandom_range(0, 200000)) - 100000;
               fy = longint'($urandom_range(0, 200000)) - 100000;
               fz = longint'($urandom_range(0, 200000)) - 100000;
               for (int i = 0; i < NUM_PLANES; i++) begin
                  nx      = int'($urandom_range(0, 1023)) - 512;
                  ny      = int'($urandom_range(0, 1023)) - 512;
                  nz      = int'($urandom_range(0, 1023)) - 512;
                  margin  = longint'($urandom_range(0, 220000)) - 20000;
                  bank[i] = pack_plane(nx, ny, nz, nx * fx + ny * fy + nz * fz - margin);
               end
               spread = 600;
            end
            default: begin
               for (int i = 0; i < NUM_PLANES; i++)
                  bank[i] = {$urandom, $urandom};
               fx = 0;
               fy = 0;
               fz = 0;
               spread = COORD_MAX;
            end
         endcase

         load_planes(bank, (p % 2) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // each cycle idles with the phase's odds before the next request
            while (int'($urandom_range(0, 99)) < idle_pct) begin
               start <= 1'b0;
               @(posedge clock);
            end
            send_random_box(fx, fy, fz, spread);
         end
      end

      settle();

      $display("Checked %0d boxes over %0d plane settings: %0d visible, %0d culled.",
               boxes_checked, plane_sets, boxes_visible, boxes_checked - boxes_visible);
      $display("%0d register writes incl. unused indexes; sender idle at 0, 56 and 36 pct.",
               csr_writes);
      if (mismatches == 0 && pending_results == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
